// ===== rtl/evm_pkg.sv =====
// ----------------------------------------------------------------------------
// evm_pkg
// Shared types and constants for the Euler Y-X-Z view matrix core.
// ----------------------------------------------------------------------------
package evm_pkg;

   // Sine and cosine of one angle, signed Q30 (range +-1.0)
   typedef struct packed {
      logic signed [31:0] sn;
      logic signed [31:0] cs;
   } trig_type;

   // Pipeline depth of the sine/cosine unit, in register stages
   localparam int SINCOS_LAT = 22;

endpackage

// ===== rtl/evm_sincos.sv =====
// ----------------------------------------------------------------------------
// evm_sincos
// Pipelined sine/cosine of a binary angle: octant folding, radian scaling
// and Horner Taylor series (sine to x^11, cosine to x^12), Q30 output.
// ----------------------------------------------------------------------------
module evm_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output evm_pkg::trig_type     trig
);

   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [29:0] EIGHTH_TURN = 30'h2000_0000;
   localparam int          STEPS       = 6;
   localparam int          SIN_STEPS   = 5;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [1:0]  quad;
      logic        refl;
   } horner_type;

   // Series divisors, innermost term first
   function automatic int cos_div(input int j);
      case (j)
         0:       return 132;
         1:       return 90;
         2:       return 56;
         3:       return 30;
         4:       return 12;
         default: return 2;
      endcase
   endfunction

   function automatic int sin_div(input int j);
      case (j)
         0:       return 110;
         1:       return 72;
         2:       return 42;
         3:       return 20;
         4:       return 6;
         default: return 1;
      endcase
   endfunction

   // Stage A: fold the angle into [0, 1/8 turn]
   logic [31:0] phase;
   logic [29:0] r_raw;
   logic        refl_in;
   logic [29:0] r_in;
   logic [29:0] r_a_ff;
   logic [1:0]  quad_a_ff;
   logic        refl_a_ff;

   assign phase   = {angle, {(32-ANGLE_BITS){1'b0}}};
   assign r_raw   = phase[29:0];
   assign refl_in = r_raw > EIGHTH_TURN;
   assign r_in    = refl_in ? 30'(ONE_Q30 - {1'b0, r_raw}) : r_raw;

   always_ff @(posedge clock) begin
      if (en) begin
         r_a_ff    <= r_in;
         quad_a_ff <= phase[31:30];
         refl_a_ff <= refl_in;
      end
   end

   // Stage B: radians, x = r * pi/2
   logic [60:0] prod_b;
   horner_type  ctx_b_ff;

   assign prod_b = 61'(r_a_ff) * 61'(HALF_PI_Q30) + (61'd1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_b_ff.x    <= prod_b[59:30];
         ctx_b_ff.x2   <= '0;
         ctx_b_ff.quad <= quad_a_ff;
         ctx_b_ff.refl <= refl_a_ff;
      end
   end

   // Stage C: x squared
   logic [59:0] prod_c;
   horner_type  ctx_c_ff;

   assign prod_c = 60'(ctx_b_ff.x) * 60'(ctx_b_ff.x) + (60'd1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_c_ff.x    <= ctx_b_ff.x;
         ctx_c_ff.x2   <= prod_c[59:30];
         ctx_c_ff.quad <= ctx_b_ff.quad;
         ctx_c_ff.refl <= ctx_b_ff.refl;
      end
   end

   // Horner chain: three stages per term, sine and cosine side by side
   logic [30:0] hs_w  [0:STEPS];
   logic [30:0] hc_w  [0:STEPS];
   horner_type  ctx_w [0:STEPS];

   assign hs_w[0]  = ONE_Q30;
   assign hc_w[0]  = ONE_Q30;
   assign ctx_w[0] = ctx_c_ff;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int              CD   = cos_div(j);
      localparam int              SD   = sin_div(j);
      localparam bit              LAST = (j == SIN_STEPS);
      localparam int              KC   = 30 + $clog2(CD);
      localparam int              KS   = 30 + $clog2(SD);
      localparam longint unsigned MC   = (64'd1 << KC) / 64'(CD);
      localparam longint unsigned MS   = (64'd1 << KS) / 64'(SD);

      logic [60:0] pc1, ps1, pc2, ps2;
      logic [29:0] ms1;
      logic [37:0] qdc, qds;
      logic [29:0] remc, rems;
      logic [29:0] qc3, qs3;
      logic [29:0] tc1_ff, ts1_ff, tc2_ff, ts2_ff, qc2_ff, qs2_ff;
      logic [30:0] hc3_ff, hs3_ff;
      horner_type  ctx1_ff, ctx2_ff, ctx3_ff;

      // S1: t = x2*h (sine's last term takes x*h instead)
      assign ms1 = LAST ? ctx_w[j].x : ctx_w[j].x2;
      assign pc1 = 61'(ctx_w[j].x2) * 61'(hc_w[j]);
      assign ps1 = 61'(ms1) * 61'(hs_w[j]);

      always_ff @(posedge clock) begin
         if (en) begin
            tc1_ff  <= pc1[59:30];
            ts1_ff  <= ps1[59:30];
            ctx1_ff <= ctx_w[j];
         end
      end

      // S2: quotient estimate by reciprocal, low by at most one
      assign pc2 = 61'(tc1_ff) * 61'(MC);
      assign ps2 = 61'(ts1_ff) * 61'(MS);

      always_ff @(posedge clock) begin
         if (en) begin
            tc2_ff  <= tc1_ff;
            ts2_ff  <= ts1_ff;
            qc2_ff  <= 30'(pc2 >> KC);
            qs2_ff  <= 30'(ps2 >> KS);
            ctx2_ff <= ctx1_ff;
         end
      end

      // S3: correct quotient, h = 1 - t/d (sine's last term takes h = t)
      assign qdc  = 38'(qc2_ff) * 38'(CD);
      assign qds  = 38'(qs2_ff) * 38'(SD);
      assign remc = tc2_ff - 30'(qdc);
      assign rems = ts2_ff - 30'(qds);
      assign qc3  = qc2_ff + 30'(remc >= 30'(CD));
      assign qs3  = qs2_ff + 30'(rems >= 30'(SD));

      always_ff @(posedge clock) begin
         if (en) begin
            hc3_ff  <= ONE_Q30 - 31'(qc3);
            hs3_ff  <= LAST ? 31'(ts2_ff) : ONE_Q30 - 31'(qs3);
            ctx3_ff <= ctx2_ff;
         end
      end

      assign hs_w[j+1]  = hs3_ff;
      assign hc_w[j+1]  = hc3_ff;
      assign ctx_w[j+1] = ctx3_ff;
   end

   // Stage D: undo octant fold and apply quadrant
   logic signed [31:0] s0, c0, sf, cf;
   evm_pkg::trig_type  trig_in, trig_ff;

   always_comb begin
      sf = $signed({1'b0, hs_w[STEPS]});
      cf = $signed({1'b0, hc_w[STEPS]});
      s0 = ctx_w[STEPS].refl ? cf : sf;
      c0 = ctx_w[STEPS].refl ? sf : cf;
      case (ctx_w[STEPS].quad)
         QUAD_I: begin
            trig_in.sn = s0;
            trig_in.cs = c0;
         end
         QUAD_II: begin
            trig_in.sn = c0;
            trig_in.cs = -s0;
         end
         QUAD_III: begin
            trig_in.sn = -s0;
            trig_in.cs = -c0;
         end
         default: begin
            trig_in.sn = -c0;
            trig_in.cs = s0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

// ===== rtl/euler_yxz_view_matrix_core.sv =====
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_core
// Camera view matrix from position and Y-X-Z Euler angles, fixed point.
// ----------------------------------------------------------------------------
// Request channel (req_*): camera position (signed Q16.16) and pitch, yaw,
// roll as binary angles. Result channel (rsp_*): the right, up and forward
// basis vectors (signed Q1.14) and the translation column (Q16.16,
// saturated), one result per request.
// Both channels use valid/stall; a request is taken on a clock edge with
// valid high and stall low.
// A request passes through the sine/cosine units (octant fold, radian
// scale, six three-stage Horner terms), then the basis products and
// rounding (P1 to P4), then the dot products and saturation (T1 to T4).
// Throughput is one request per cycle unless a waiting result is stalled.
// The whole pipeline advances while the output register is empty or being
// taken; when the receiver stalls a waiting result, every stage holds and
// req_stall rises until it is taken. A synchronous reset clears only the
// valid bits; nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix_core #(
   parameter int POS_BITS   = 32,
   parameter int ANGLE_BITS = 16,
   parameter int COEF_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_BITS-1:0]  req_pos_x,
   input  logic signed [POS_BITS-1:0]  req_pos_y,
   input  logic signed [POS_BITS-1:0]  req_pos_z,
   input  logic signed [ANGLE_BITS-1:0] req_angle_x,
   input  logic signed [ANGLE_BITS-1:0] req_angle_y,
   input  logic signed [ANGLE_BITS-1:0] req_angle_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [COEF_BITS-1:0] rsp_right_x,
   output logic signed [COEF_BITS-1:0] rsp_right_y,
   output logic signed [COEF_BITS-1:0] rsp_right_z,
   output logic signed [COEF_BITS-1:0] rsp_up_x,
   output logic signed [COEF_BITS-1:0] rsp_up_y,
   output logic signed [COEF_BITS-1:0] rsp_up_z,
   output logic signed [COEF_BITS-1:0] rsp_fwd_x,
   output logic signed [COEF_BITS-1:0] rsp_fwd_y,
   output logic signed [COEF_BITS-1:0] rsp_fwd_z,
   output logic signed [POS_BITS-1:0]  rsp_trans_x,
   output logic signed [POS_BITS-1:0]  rsp_trans_y,
   output logic signed [POS_BITS-1:0]  rsp_trans_z
);

   localparam int COEF_FRAC = COEF_BITS - 2;
   localparam int RND_SH    = 30 - COEF_FRAC;
   localparam int POS_DLY   = evm_pkg::SINCOS_LAT + 4;
   localparam int PIPE_LAT  = evm_pkg::SINCOS_LAT + 8;
   localparam int LO_BITS   = POS_BITS / 2;
   localparam int HI_BITS   = POS_BITS - LO_BITS;
   localparam int PLW       = COEF_BITS + LO_BITS + 1;
   localparam int PHW       = COEF_BITS + HI_BITS;
   localparam int TW        = COEF_BITS + POS_BITS + 2;
   localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (POS_BITS-1)) - 64'sd1);
   localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);
   localparam logic [32:0] COEF_ONE = 33'd1 << COEF_FRAC;

   // Q30 product, magnitude rounded half away from zero
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic [30:0] ma, mb;
      logic [61:0] pr;
      logic [31:0] p;
      ma = a[31] ? 31'(-a) : 31'(a);
      mb = b[31] ? 31'(-b) : 31'(b);
      pr = 62'(ma) * 62'(mb) + (62'd1 << 29);
      p  = 32'(pr >> 30);
      return (a[31] != b[31]) ? -$signed(p) : $signed(p);
   endfunction

   // Q30 to basis format, half away from zero, clamped to +-1.0
   function automatic logic signed [COEF_BITS-1:0] to_coef(input logic signed [32:0] v);
      logic [32:0] mg, m;
      mg = v[32] ? 33'(-v) : 33'(v);
      m  = (mg + (33'd1 << (RND_SH-1))) >> RND_SH;
      if (m > COEF_ONE) begin
         m = COEF_ONE;
      end
      return v[32] ? COEF_BITS'(-$signed(m)) : COEF_BITS'(m);
   endfunction

   // Pipeline advance and valid bits
   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;

   assign en        = !vld_ff[PIPE_LAT-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   // Sine/cosine units: x gives s2,c2; y gives s1,c1; z gives s3,c3
   evm_pkg::trig_type trig_x, trig_y, trig_z;

   evm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_x (
      .clock(clock), .en(en), .angle(req_angle_x), .trig(trig_x));
   evm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_y (
      .clock(clock), .en(en), .angle(req_angle_y), .trig(trig_y));
   evm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_z (
      .clock(clock), .en(en), .angle(req_angle_z), .trig(trig_z));

   // Position delay line, aligned with the basis entries
   logic signed [POS_BITS-1:0] pos_dly_ff [0:POS_DLY-1][0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         pos_dly_ff[0][0] <= req_pos_x;
         pos_dly_ff[0][1] <= req_pos_y;
         pos_dly_ff[0][2] <= req_pos_z;
         for (int k = 1; k < POS_DLY; k++) begin
            pos_dly_ff[k] <= pos_dly_ff[k-1];
         end
      end
   end

   // P1: first-level products
   logic signed [31:0] c1c3_1_ff, s1s2_1_ff, c2s3_1_ff, c1s2_1_ff, c3s1_1_ff;
   logic signed [31:0] c1s3_1_ff, c2c3_1_ff, s1s3_1_ff, c2s1_1_ff, c1c2_1_ff;
   logic signed [31:0] s2_1_ff, s3_1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1c3_1_ff <= qmul(trig_y.cs, trig_z.cs);
         s1s2_1_ff <= qmul(trig_y.sn, trig_x.sn);
         c2s3_1_ff <= qmul(trig_x.cs, trig_z.sn);
         c1s2_1_ff <= qmul(trig_y.cs, trig_x.sn);
         c3s1_1_ff <= qmul(trig_z.cs, trig_y.sn);
         c1s3_1_ff <= qmul(trig_y.cs, trig_z.sn);
         c2c3_1_ff <= qmul(trig_x.cs, trig_z.cs);
         s1s3_1_ff <= qmul(trig_y.sn, trig_z.sn);
         c2s1_1_ff <= qmul(trig_x.cs, trig_y.sn);
         c1c2_1_ff <= qmul(trig_y.cs, trig_x.cs);
         s2_1_ff   <= trig_x.sn;
         s3_1_ff   <= trig_z.sn;
      end
   end

   // P2: triple products
   logic signed [31:0] c1c3_2_ff, s1s2s3_2_ff, c2s3_2_ff, c1s2s3_2_ff, c3s1_2_ff;
   logic signed [31:0] c3s1s2_2_ff, c1s3_2_ff, c2c3_2_ff, c1c3s2_2_ff, s1s3_2_ff;
   logic signed [31:0] c2s1_2_ff, s2_2_ff, c1c2_2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1c3_2_ff   <= c1c3_1_ff;
         s1s2s3_2_ff <= qmul(s1s2_1_ff, s3_1_ff);
         c2s3_2_ff   <= c2s3_1_ff;
         c1s2s3_2_ff <= qmul(c1s2_1_ff, s3_1_ff);
         c3s1_2_ff   <= c3s1_1_ff;
         c3s1s2_2_ff <= qmul(c3s1_1_ff, s2_1_ff);
         c1s3_2_ff   <= c1s3_1_ff;
         c2c3_2_ff   <= c2c3_1_ff;
         c1c3s2_2_ff <= qmul(c1c3_1_ff, s2_1_ff);
         s1s3_2_ff   <= s1s3_1_ff;
         c2s1_2_ff   <= c2s1_1_ff;
         s2_2_ff     <= s2_1_ff;
         c1c2_2_ff   <= c1c2_1_ff;
      end
   end

   // P3: basis entries in Q30
   logic signed [32:0] bq_ff [0:8];

   always_ff @(posedge clock) begin
      if (en) begin
         bq_ff[0] <= 33'(c1c3_2_ff) + 33'(s1s2s3_2_ff);
         bq_ff[1] <= 33'(c2s3_2_ff);
         bq_ff[2] <= 33'(c1s2s3_2_ff) - 33'(c3s1_2_ff);
         bq_ff[3] <= 33'(c3s1s2_2_ff) - 33'(c1s3_2_ff);
         bq_ff[4] <= 33'(c2c3_2_ff);
         bq_ff[5] <= 33'(c1c3s2_2_ff) + 33'(s1s3_2_ff);
         bq_ff[6] <= 33'(c2s1_2_ff);
         bq_ff[7] <= -33'(s2_2_ff);
         bq_ff[8] <= 33'(c1c2_2_ff);
      end
   end

   // P4 and on: rounded basis entries, carried to the output
   logic signed [COEF_BITS-1:0] coef_ff [0:4][0:8];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            coef_ff[0][i] <= to_coef(bq_ff[i]);
         end
         for (int k = 1; k < 5; k++) begin
            coef_ff[k] <= coef_ff[k-1];
         end
      end
   end

   // T1: split partial products of basis entry and position
   logic signed [PLW-1:0]      plo_ff [0:2][0:2];
   logic signed [PHW-1:0]      phi_ff [0:2][0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
               plo_ff[v][k] <= PLW'(coef_ff[0][3*v+k])
                  * $signed({1'b0, pos_dly_ff[POS_DLY-1][k][LO_BITS-1:0]});
               phi_ff[v][k] <= PHW'(coef_ff[0][3*v+k])
                  * PHW'($signed(pos_dly_ff[POS_DLY-1][k][POS_BITS-1:LO_BITS]));
            end
         end
      end
   end

   // T2: sum the three terms of each half
   logic signed [PLW+1:0] slo_ff [0:2];
   logic signed [PHW+1:0] shi_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 3; v++) begin
            slo_ff[v] <= (PLW+2)'(plo_ff[v][0]) + (PLW+2)'(plo_ff[v][1])
                       + (PLW+2)'(plo_ff[v][2]);
            shi_ff[v] <= (PHW+2)'(phi_ff[v][0]) + (PHW+2)'(phi_ff[v][1])
                       + (PHW+2)'(phi_ff[v][2]);
         end
      end
   end

   // T3: join halves and add the rounding half
   logic signed [TW-1:0] tot_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 3; v++) begin
            tot_ff[v] <= (TW'(shi_ff[v]) <<< LO_BITS) + TW'(slo_ff[v])
                       + (TW'(1) <<< (COEF_FRAC-1));
         end
      end
   end

   // T4: scale, negate, saturate
   logic signed [TW-1:0]       neg_t [0:2];
   logic signed [POS_BITS-1:0] trans_ff [0:2];

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         neg_t[v] = -(tot_ff[v] >>> COEF_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int v = 0; v < 3; v++) begin
            if (neg_t[v] > SAT_HI) begin
               trans_ff[v] <= POS_BITS'(SAT_HI);
            end else if (neg_t[v] < SAT_LO) begin
               trans_ff[v] <= POS_BITS'(SAT_LO);
            end else begin
               trans_ff[v] <= POS_BITS'(neg_t[v]);
            end
         end
      end
   end

   assign rsp_right_x = coef_ff[4][0];
   assign rsp_right_y = coef_ff[4][1];
   assign rsp_right_z = coef_ff[4][2];
   assign rsp_up_x    = coef_ff[4][3];
   assign rsp_up_y    = coef_ff[4][4];
   assign rsp_up_z    = coef_ff[4][5];
   assign rsp_fwd_x   = coef_ff[4][6];
   assign rsp_fwd_y   = coef_ff[4][7];
   assign rsp_fwd_z   = coef_ff[4][8];
   assign rsp_trans_x = trans_ff[0];
   assign rsp_trans_y = trans_ff[1];
   assign rsp_trans_z = trans_ff[2];

endmodule

// ===== rtl/evm_checker.sv =====
// ----------------------------------------------------------------------------
// evm_checker
// Port-level checks for the view matrix core, bound to the top level.
// ----------------------------------------------------------------------------
module evm_checker #(
   parameter int POS_BITS  = 32,
   parameter int COEF_BITS = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [COEF_BITS-1:0] rsp_right_x,
   input logic signed [COEF_BITS-1:0] rsp_fwd_y,
   input logic signed [POS_BITS-1:0]  rsp_trans_x
);

   localparam logic signed [COEF_BITS-1:0] C_ONE = COEF_BITS'(1) <<< (COEF_BITS-2);

   // A stalled result stays valid and keeps right_x and trans_x
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_trans_x)
                                 && $stable(rsp_right_x))
      else $error("stalled result changed");

   // Requests are only held off behind a blocked result
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked result");

   // Basis entries right_x and fwd_y stay within +-1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_right_x <= C_ONE && rsp_right_x >= -C_ONE
                    && rsp_fwd_y <= C_ONE && rsp_fwd_y >= -C_ONE)
      else $error("basis entry out of range");

   // Reset leaves no valid result
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind euler_yxz_view_matrix_core evm_checker #(
   .POS_BITS(POS_BITS),
   .COEF_BITS(COEF_BITS)
) u_evm_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_right_x(rsp_right_x),
   .rsp_fwd_y(rsp_fwd_y),
   .rsp_trans_x(rsp_trans_x)
);
